// ----- rtl/core/refcounted_page_allocator_assert.svh -----
// Assertion macros shared by the page allocator RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock edge,
// disabled while the asynchronous reset is asserted.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int NUM_PAGES   = 32768;
	localparam int PAGE_W      = 15;
	localparam int IDX_W       = $clog2(NUM_PAGES);
	localparam int CNT_W       = 8;
	localparam int CFG_W       = 32;
	localparam int ADDR_W      = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(255);
	localparam logic [CNT_W-1:0] CNT_COPY_MIN = CNT_W'(2);

	// Command codes of the input channel.
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_ADDREF  = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_FAULT   = 2'd3;

	// Status codes of the output channel.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_COUNT  = 2'd3;

	// Register index decoded from the configuration address.
	localparam logic [ADDR_W-3:0] REG_FIRST_USABLE = '0;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_ADDREF,
		OP_RELEASE,
		OP_FAULT,
		OP_RANGE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [PAGE_W-1:0] page;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] page_out;
		logic [CNT_W-1:0]  ref_count;
		logic              pushed_free;
		logic              copy_needed;
	} result_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC,
		BK_FIX,
		BK_HOLD
	} bk_state_t;

endpackage

// ----- rtl/core/rpa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_front
// Configuration register and command front end: accepts commands, decodes
// them and flags pages outside the usable range before queueing.
// ----------------------------------------------------------------------------
module rpa_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpa_pkg::ADDR_W-1:0]   paddr,
	input  logic [rpa_pkg::CFG_W-1:0]    pwdata,
	output logic [rpa_pkg::CFG_W-1:0]    prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic [rpa_pkg::PAGE_W-1:0]   page,
	input  logic                         q_full,
	input  logic                         clearing,
	output logic                         q_push,
	output rpa_pkg::item_t               q_item
);

	logic [rpa_pkg::PAGE_W-1:0] first_usable_q;
	logic                       reg_hit;
	logic                       out_of_range;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[rpa_pkg::ADDR_W-1:2] == rpa_pkg::REG_FIRST_USABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_usable_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			first_usable_q <= pwdata[rpa_pkg::PAGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(rpa_pkg::CFG_W-rpa_pkg::PAGE_W){1'b0}}, first_usable_q};
		end
	end

	// No new commands while the count memory is being cleared after reset.
	assign in_stall = q_full || clearing;
	assign q_push   = in_valid && !in_stall;

	assign out_of_range = (page < first_usable_q) ||
		({1'b0, page} >= (rpa_pkg::PAGE_W+1)'(rpa_pkg::NUM_PAGES));

	always_comb begin
		q_item.page = page;
		case (cmd)
			rpa_pkg::CMD_ALLOC:   q_item.op = rpa_pkg::OP_ALLOC;
			rpa_pkg::CMD_ADDREF:  q_item.op = rpa_pkg::OP_ADDREF;
			rpa_pkg::CMD_RELEASE: q_item.op = rpa_pkg::OP_RELEASE;
			rpa_pkg::CMD_FAULT:   q_item.op = rpa_pkg::OP_FAULT;
			default:              q_item.op = rpa_pkg::OP_RANGE;
		endcase
		if (cmd != rpa_pkg::CMD_ALLOC && out_of_range) begin
			q_item.op = rpa_pkg::OP_RANGE;
		end
	end

endmodule

// ----- rtl/core/rpa_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_queue
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module rpa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpa_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output rpa_pkg::item_t head_item
);

	localparam int PTR_W = $clog2(rpa_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rpa_pkg::QUEUE_DEPTH + 1);

	rpa_pkg::item_t   entries_q [rpa_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(rpa_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(rpa_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/rpa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_back
// Execution back end: count and link memories, free-list head, command
// sequencer and the output register.
// ----------------------------------------------------------------------------
module rpa_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  rpa_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_stall,
	output rpa_pkg::result_t             result
);

	localparam int PW = rpa_pkg::PAGE_W;
	localparam int IW = rpa_pkg::IDX_W;
	localparam int CW = rpa_pkg::CNT_W;

	// Count memory and link memory; a link word is {end-of-list, next page}.
	logic [CW-1:0] cnt_mem  [rpa_pkg::NUM_PAGES];
	logic [PW:0]   link_mem [rpa_pkg::NUM_PAGES];

	rpa_pkg::bk_state_t state_q, state_d;
	logic [IW-1:0]      clr_q;
	logic [PW-1:0]      head_q, head_d;
	logic               empty_q, empty_d;
	rpa_pkg::item_t     cur_q;
	logic [CW-1:0]      cnt_rd_q;
	logic [PW:0]        link_rd_q;
	logic [PW-1:0]      fix_page_q;
	rpa_pkg::result_t   res, res_q, out_q;
	logic               out_valid_q;

	logic          cnt_we;
	logic [IW-1:0] cnt_wa;
	logic [CW-1:0] cnt_wd;
	logic          link_we;
	logic          need_fix;
	logic          out_free;
	logic          load_out;
	logic [CW-1:0] cnt;

	assign cnt       = cnt_rd_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign clearing  = (state_q == rpa_pkg::BK_CLEAR);
	assign q_pop     = (state_q == rpa_pkg::BK_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	// Memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[q_item.page[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[cur_q.page[IW-1:0]] <= {empty_q, head_q};
		end
		link_rd_q <= link_mem[head_q[IW-1:0]];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpa_pkg::BK_CLEAR: begin
				if (clr_q == IW'(rpa_pkg::NUM_PAGES - 1)) begin
					state_d = rpa_pkg::BK_IDLE;
				end
			end
			rpa_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_d = rpa_pkg::BK_EXEC;
				end
			end
			rpa_pkg::BK_EXEC: begin
				if (need_fix) begin
					state_d = rpa_pkg::BK_FIX;
				end else if (out_free) begin
					state_d = rpa_pkg::BK_IDLE;
				end else begin
					state_d = rpa_pkg::BK_HOLD;
				end
			end
			rpa_pkg::BK_FIX: state_d = rpa_pkg::BK_HOLD;
			rpa_pkg::BK_HOLD: begin
				if (out_free) begin
					state_d = rpa_pkg::BK_IDLE;
				end
			end
			default: state_d = rpa_pkg::BK_IDLE;
		endcase
	end

	// Datapath actions of each state.
	always_comb begin
		res      = '0;
		cnt_we   = 1'b0;
		cnt_wa   = cur_q.page[IW-1:0];
		cnt_wd   = '0;
		link_we  = 1'b0;
		head_d   = head_q;
		empty_d  = empty_q;
		need_fix = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rpa_pkg::BK_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
			end
			rpa_pkg::BK_EXEC: begin
				case (cur_q.op)
					rpa_pkg::OP_ALLOC: begin
						if (empty_q) begin
							res.status = rpa_pkg::ST_NOFREE;
						end else begin
							cnt_we        = 1'b1;
							cnt_wa        = head_q[IW-1:0];
							cnt_wd        = CW'(1);
							head_d        = link_rd_q[PW-1:0];
							empty_d       = link_rd_q[PW];
							res.page_out  = head_q;
							res.ref_count = CW'(1);
						end
					end
					rpa_pkg::OP_ADDREF: begin
						if (cnt == rpa_pkg::CNT_MAX) begin
							res.status    = rpa_pkg::ST_COUNT;
							res.ref_count = cnt;
						end else begin
							cnt_we        = 1'b1;
							cnt_wd        = cnt + CW'(1);
							res.ref_count = cnt + CW'(1);
						end
					end
					rpa_pkg::OP_RELEASE: begin
						if (cnt == '0) begin
							res.status = rpa_pkg::ST_COUNT;
						end else begin
							cnt_we        = 1'b1;
							cnt_wd        = cnt - CW'(1);
							res.ref_count = cnt - CW'(1);
							if (cnt == CW'(1)) begin
								// Last reference gone: push onto the free list.
								link_we         = 1'b1;
								head_d          = cur_q.page;
								empty_d         = 1'b0;
								res.pushed_free = 1'b1;
							end
						end
					end
					rpa_pkg::OP_FAULT: begin
						res.ref_count = cnt;
						if (cnt >= rpa_pkg::CNT_COPY_MIN) begin
							if (empty_q) begin
								res.status = rpa_pkg::ST_NOFREE;
							end else begin
								res.copy_needed = 1'b1;
								res.page_out    = head_q;
								cnt_we          = 1'b1;
								if (cur_q.page == head_q) begin
									// The popped page is the faulting one: it goes
									// straight back to the head, so the list is unchanged.
									cnt_wd          = '0;
									res.ref_count   = '0;
									res.pushed_free = 1'b1;
								end else begin
									cnt_wd        = cnt - CW'(1);
									res.ref_count = cnt - CW'(1);
									head_d        = link_rd_q[PW-1:0];
									empty_d       = link_rd_q[PW];
									need_fix      = 1'b1;
								end
							end
						end
					end
					rpa_pkg::OP_RANGE: res.status = rpa_pkg::ST_RANGE;
					default: res.status = rpa_pkg::ST_RANGE;
				endcase
				load_out = !need_fix && out_free;
			end
			rpa_pkg::BK_FIX: begin
				// Second count write of a copying fault: the new page gets one reference.
				cnt_we = 1'b1;
				cnt_wa = fix_page_q[IW-1:0];
				cnt_wd = CW'(1);
			end
			rpa_pkg::BK_HOLD: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpa_pkg::BK_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpa_pkg::BK_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (state_q == rpa_pkg::BK_EXEC) begin
				head_q  <= head_d;
				empty_q <= empty_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == rpa_pkg::BK_EXEC) begin
			res_q      <= res;
			fix_page_q <= head_q;
		end
		if (load_out) begin
			out_q <= (state_q == rpa_pkg::BK_EXEC) ? res : res_q;
		end
	end

endmodule

// ----- rtl/core/refcounted_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Reference-counted physical page allocator with a LIFO free list.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ---------------------------------------
//   input     in_valid / in_stall   cmd, page
//   output    out_valid / out_stall status, page_out, ref_count,
//                                   pushed_free, copy_needed
//   config    APB write/read        first_usable_page at byte address 0
//
// In the back end a command first reads the count and link memories, then
// updates them. A copying fault whose new page differs from the faulting
// page then also needs a second count-memory write and a step that loads
// the result. After reset all 32768 count-memory entries are cleared, one
// entry a cycle; in_stall stays high meanwhile. The two-entry command queue
// and the output register let the input keep flowing while a result is
// stalled, until the queue fills.
// ----------------------------------------------------------------------------
`include "refcounted_page_allocator_assert.svh"

module refcounted_page_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpa_pkg::ADDR_W-1:0]   paddr,
	input  logic [rpa_pkg::CFG_W-1:0]    pwdata,
	output logic [rpa_pkg::CFG_W-1:0]    prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic [rpa_pkg::PAGE_W-1:0]   page,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [rpa_pkg::PAGE_W-1:0]   page_out,
	output logic [rpa_pkg::CNT_W-1:0]    ref_count,
	output logic                         pushed_free,
	output logic                         copy_needed
);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_valid;
	logic             clearing;
	rpa_pkg::item_t   push_item;
	rpa_pkg::item_t   head_item;
	rpa_pkg::result_t result;

	rpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.page     (page),
		.q_full   (q_full),
		.clearing (clearing),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	rpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head_item (head_item)
	);

	rpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign status      = result.status;
	assign page_out    = result.page_out;
	assign ref_count   = result.ref_count;
	assign pushed_free = result.pushed_free;
	assign copy_needed = result.copy_needed;

	`RPA_ASSERT_IMP(a_stall_while_clearing, clk, arst_n, clearing, in_stall,
		"command accepted during the count clearing pass")

	`RPA_ASSERT_NXT(a_clear_once, clk, arst_n, !clearing, !clearing,
		"count clearing pass restarted without reset")

	`RPA_ASSERT_IMP(a_range_fields_zero, clk, arst_n,
		out_valid && (status == rpa_pkg::ST_RANGE),
		(page_out == '0) && (ref_count == '0) && !pushed_free && !copy_needed,
		"out-of-range result carries nonzero fields")

	`RPA_ASSERT_IMP(a_flags_need_ok, clk, arst_n,
		out_valid && (pushed_free || copy_needed), status == rpa_pkg::ST_OK,
		"push or copy flagged on a failed command")

endmodule
